[rtl/octw_pkg.sv]
// Shared types and constants for the OPL capture to timed writes block.
// No dependencies; used by opl_capture_to_timed_writes.
package octw_pkg;

    // Item operation codes on the input channel
    typedef enum logic [1:0] {
        OP_BYTE        = 2'd0,
        OP_TABLE_WRITE = 2'd1,
        OP_END         = 2'd2
    } op_t;

    // Result kinds on the output channel
    typedef enum logic [1:0] {
        KIND_RECORD  = 2'd0,
        KIND_WARNING = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CONTAINER_VERSION = 2'd0,
        CFG_SHORT_DELAY_CODE  = 2'd1,
        CFG_LONG_DELAY_CODE   = 2'd2,
        CFG_OUTPUT_RATE_HZ    = 2'd3
    } cfg_index_t;

    // Version 0.1 command bytes
    localparam logic [7:0] CMD_SHORT_DELAY  = 8'h00;
    localparam logic [7:0] CMD_LONG_DELAY   = 8'h01;
    localparam logic [7:0] CMD_SECOND_CHIP  = 8'h02;
    localparam logic [7:0] CMD_SECOND_CHIP2 = 8'h03;
    localparam logic [7:0] CMD_ESCAPE       = 8'h04;

    // Version 2 high bank and second-chip detection
    localparam int unsigned HIGH_BANK_BIT = 7;
    localparam logic [7:0]  KEY_ON_FIRST  = 8'hB0;
    localparam logic [7:0]  KEY_ON_LAST   = 8'hB8;
    localparam int unsigned KEY_ON_BIT    = 5;

    // Reset values of the configuration registers
    localparam logic [7:0]  SHORT_CODE_RESET = 8'h00;
    localparam logic [7:0]  LONG_CODE_RESET  = 8'h01;
    localparam logic [14:0] RATE_RESET       = 15'd560;

    // Divide by 1000: drop three bits, then multiply by ceil(2^35 / 125)
    // and take bits from 35 up. Exact for every 28-bit dividend.
    localparam int unsigned PROD_W      = 31;
    localparam int unsigned DIV_PRE     = 3;
    localparam int unsigned DIV_IN_W    = PROD_W - DIV_PRE;
    localparam int unsigned RECIP_W     = 29;
    localparam logic [RECIP_W-1:0] RECIP_125 = 29'd274877907;
    localparam int unsigned DIV_SHIFT   = 35;
    localparam int unsigned DIV_OUT_W   = DIV_IN_W + RECIP_W;

    // Body length: four bytes of header plus four per record
    localparam logic [15:0] LENGTH_BASE = 16'd4;

endpackage

[rtl/opl_capture_to_timed_writes.sv]
// A result reaches the output register after the item that causes it is
// accepted, by way of the parse stage and then the divide stage; items that cause no
// result finish in the cycle they are accepted.
// Throughput: one item per cycle; the input stalls only while the output is
// stalled and both pipeline stages are full.
// Reset (rst_n, asynchronous, active low): parser idle, delay and count clear,
// warning armed, registers at their defaults; the code table is not cleared.
// Depends on octw_pkg.
module opl_capture_to_timed_writes #(
    parameter int unsigned CODE_TABLE_DEPTH = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // configuration write port
    input  logic                                cfg_write_en,
    input  logic [1:0]                          cfg_index,
    input  logic [14:0]                         cfg_data,

    // item channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [1:0]                          op,
    input  logic [7:0]                          stream_byte,
    input  logic [$clog2(CODE_TABLE_DEPTH)-1:0] map_index,
    input  logic [7:0]                          map_value,

    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [1:0]                          kind,
    output logic [15:0]                         delay_ticks,
    output logic [7:0]                          chip_register,
    output logic [7:0]                          chip_value,
    output logic [15:0]                         body_length
);

    localparam int unsigned TABLE_AW = $clog2(CODE_TABLE_DEPTH);

    // Parser phases: which byte of a command is expected next
    typedef enum logic [2:0] {
        PH_CMD       = 3'd0,
        PH_SHORT     = 3'd1,
        PH_LONG_LO   = 3'd2,
        PH_LONG_HI   = 3'd3,
        PH_V2_LONG   = 3'd4,
        PH_DATA      = 3'd5,
        PH_HIGH_DATA = 3'd6,
        PH_ESC_REG   = 3'd7
    } phase_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        version_reg;
    logic [7:0]  short_code_reg;
    logic [7:0]  long_code_reg;
    logic [14:0] rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg    <= 1'b0;
            short_code_reg <= octw_pkg::SHORT_CODE_RESET;
            long_code_reg  <= octw_pkg::LONG_CODE_RESET;
            rate_reg       <= octw_pkg::RATE_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                octw_pkg::CFG_CONTAINER_VERSION: version_reg    <= cfg_data[0];
                octw_pkg::CFG_SHORT_DELAY_CODE:  short_code_reg <= cfg_data[7:0];
                octw_pkg::CFG_LONG_DELAY_CODE:   long_code_reg  <= cfg_data[7:0];
                octw_pkg::CFG_OUTPUT_RATE_HZ:    rate_reg       <= cfg_data;
                default:                         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline flow
    // Stage 1 holds the scaled-delay product, stage 2 is the output
    // register. Stage 1 drains whenever the output register is free.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_move;
    logic accept;

    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_move    = s1_valid_reg && out_free;
    assign item_stall = s1_valid_reg && !out_free;
    assign accept     = item_valid && !item_stall;

    // ------------------------------------------------------------------
    // Code table: written by table transactions, read once per version 2
    // index byte. The read data register doubles as the held register for
    // mapped writes.
    // ------------------------------------------------------------------
    logic [7:0] code_table [CODE_TABLE_DEPTH];
    logic [7:0] table_rd_reg;
    logic       table_rd_en;

    always_ff @(posedge clk)
    begin
        if (accept && op == octw_pkg::OP_TABLE_WRITE)
        begin
            code_table[map_index] <= map_value;
        end
        if (table_rd_en)
        begin
            table_rd_reg <= code_table[stream_byte[TABLE_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    phase_t      phase_reg, phase_next;
    logic [15:0] pending_reg, pending_next;
    logic [7:0]  low_byte_reg, low_byte_next;
    logic [7:0]  held_reg, held_next;
    logic        held_sel_reg, held_sel_next;   // 1: register comes from the table
    logic        armed_reg, armed_next;
    logic [13:0] count_reg, count_next;

    logic [7:0]  held_value;
    assign held_value = held_sel_reg ? table_rd_reg : held_reg;

    // What this transaction sends down the pipeline
    logic                   emit;
    logic                   emit_timed;
    octw_pkg::kind_t        emit_kind;
    logic [7:0]             emit_reg;
    logic [7:0]             emit_val;
    logic [15:0]            emit_len;
    logic [octw_pkg::PROD_W-1:0] scaled_prod;

    assign scaled_prod = octw_pkg::PROD_W'(pending_reg) * octw_pkg::PROD_W'(rate_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        pending_next  = pending_reg;
        low_byte_next = low_byte_reg;
        held_next     = held_reg;
        held_sel_next = held_sel_reg;
        armed_next    = armed_reg;
        count_next    = count_reg;
        table_rd_en   = 1'b0;
        emit          = 1'b0;
        emit_timed    = 1'b0;
        emit_kind     = octw_pkg::KIND_RECORD;
        emit_reg      = 8'h00;
        emit_val      = 8'h00;
        emit_len      = 16'h0000;

        if (accept)
        begin
            if (op == octw_pkg::OP_END)
            begin
                // Close the body and restart parsing; a cut-short command is dropped
                emit          = 1'b1;
                emit_kind     = octw_pkg::KIND_END;
                emit_len      = octw_pkg::LENGTH_BASE + {count_reg, 2'b00};
                phase_next    = PH_CMD;
                pending_next  = 16'h0000;
                low_byte_next = 8'h00;
                held_next     = 8'h00;
                held_sel_next = 1'b0;
                armed_next    = 1'b1;
                count_next    = 14'd0;
            end
            else if (op == octw_pkg::OP_BYTE)
            begin
                case (phase_reg)
                    PH_CMD:
                    begin
                        if (!version_reg)
                        begin
                            if (stream_byte == octw_pkg::CMD_SHORT_DELAY)
                            begin
                                phase_next = PH_SHORT;
                            end
                            else if (stream_byte == octw_pkg::CMD_LONG_DELAY)
                            begin
                                phase_next = PH_LONG_LO;
                            end
                            else if (stream_byte inside {octw_pkg::CMD_SECOND_CHIP,
                                                         octw_pkg::CMD_SECOND_CHIP2})
                            begin
                                if (armed_reg)
                                begin
                                    armed_next = 1'b0;
                                    emit       = 1'b1;
                                    emit_kind  = octw_pkg::KIND_WARNING;
                                end
                            end
                            else if (stream_byte == octw_pkg::CMD_ESCAPE)
                            begin
                                phase_next = PH_ESC_REG;
                            end
                            else
                            begin
                                held_next     = stream_byte;
                                held_sel_next = 1'b0;
                                phase_next    = PH_DATA;
                            end
                        end
                        else
                        begin
                            // Short code wins over long code when both match
                            if (stream_byte == short_code_reg)
                            begin
                                phase_next = PH_SHORT;
                            end
                            else if (stream_byte == long_code_reg)
                            begin
                                phase_next = PH_V2_LONG;
                            end
                            else
                            begin
                                table_rd_en   = 1'b1;
                                held_sel_next = 1'b1;
                                phase_next    = stream_byte[octw_pkg::HIGH_BANK_BIT] ?
                                                PH_HIGH_DATA : PH_DATA;
                            end
                        end
                    end
                    PH_SHORT:
                    begin
                        pending_next = pending_reg + 16'd1 + 16'(stream_byte);
                        phase_next   = PH_CMD;
                    end
                    PH_LONG_LO:
                    begin
                        low_byte_next = stream_byte;
                        phase_next    = PH_LONG_HI;
                    end
                    PH_LONG_HI:
                    begin
                        pending_next = pending_reg + 16'd1 + {stream_byte, low_byte_reg};
                        phase_next   = PH_CMD;
                    end
                    PH_V2_LONG:
                    begin
                        pending_next = pending_reg + {8'(stream_byte + 8'd1), 8'h00};
                        phase_next   = PH_CMD;
                    end
                    PH_ESC_REG:
                    begin
                        held_next     = stream_byte;
                        held_sel_next = 1'b0;
                        phase_next    = PH_DATA;
                    end
                    PH_HIGH_DATA:
                    begin
                        // High bank write: no record, but a key-on in the
                        // second chip's range reveals it
                        phase_next = PH_CMD;
                        if (armed_reg && stream_byte[octw_pkg::KEY_ON_BIT] &&
                            held_value inside {[octw_pkg::KEY_ON_FIRST:octw_pkg::KEY_ON_LAST]})
                        begin
                            armed_next = 1'b0;
                            emit       = 1'b1;
                            emit_kind  = octw_pkg::KIND_WARNING;
                        end
                    end
                    PH_DATA:
                    begin
                        emit         = 1'b1;
                        emit_timed   = 1'b1;
                        emit_kind    = octw_pkg::KIND_RECORD;
                        emit_reg     = held_value;
                        emit_val     = stream_byte;
                        pending_next = 16'h0000;
                        count_next   = count_reg + 14'd1;
                        phase_next   = PH_CMD;
                    end
                    default:
                    begin
                        phase_next = PH_CMD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CMD;
            pending_reg  <= 16'h0000;
            low_byte_reg <= 8'h00;
            held_reg     <= 8'h00;
            held_sel_reg <= 1'b0;
            armed_reg    <= 1'b1;
            count_reg    <= 14'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pending_reg  <= pending_next;
            low_byte_reg <= low_byte_next;
            held_reg     <= held_next;
            held_sel_reg <= held_sel_next;
            armed_reg    <= armed_next;
            count_reg    <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: hold the product of pending delay and rate
    // ------------------------------------------------------------------
    octw_pkg::kind_t             s1_kind_reg;
    logic [octw_pkg::PROD_W-1:0] s1_prod_reg;
    logic [7:0]                  s1_chip_reg_reg;
    logic [7:0]                  s1_val_reg;
    logic [15:0]                 s1_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            s1_kind_reg     <= emit_kind;
            s1_prod_reg     <= emit_timed ? scaled_prod : '0;
            s1_chip_reg_reg <= emit_reg;
            s1_val_reg      <= emit_val;
            s1_len_reg      <= emit_len;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: divide by 1000 with a reciprocal multiply, into the output
    // register
    // ------------------------------------------------------------------
    logic [octw_pkg::DIV_OUT_W-1:0] div_prod;
    assign div_prod = octw_pkg::DIV_OUT_W'(s1_prod_reg[octw_pkg::PROD_W-1:octw_pkg::DIV_PRE]) *
                      octw_pkg::DIV_OUT_W'(octw_pkg::RECIP_125);

    logic [1:0]  out_kind_reg;
    logic [15:0] out_ticks_reg;
    logic [7:0]  out_chip_reg_reg;
    logic [7:0]  out_val_reg;
    logic [15:0] out_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_kind_reg     <= s1_kind_reg;
            out_ticks_reg    <= div_prod[octw_pkg::DIV_SHIFT +: 16];
            out_chip_reg_reg <= s1_chip_reg_reg;
            out_val_reg      <= s1_val_reg;
            out_len_reg      <= s1_len_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign kind          = out_kind_reg;
    assign delay_ticks   = out_ticks_reg;
    assign chip_register = out_chip_reg_reg;
    assign chip_value    = out_val_reg;
    assign body_length   = out_len_reg;

`ifndef SYNTHESIS
    // The input stalls only behind a full stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg)
        else $error("input stalled with stage 1 empty");

    // An end transaction restarts the parser
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == octw_pkg::OP_END) |=>
            (phase_reg == PH_CMD && pending_reg == 16'h0000 && count_reg == 14'd0 &&
             armed_reg && s1_valid_reg && s1_kind_reg == octw_pkg::KIND_END))
        else $error("end transaction did not restart the parser");

    // Disarming the warning always queues a warning result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(armed_reg) |-> (s1_valid_reg && s1_kind_reg == octw_pkg::KIND_WARNING))
        else $error("warning disarmed without a warning result");

    // Only timed records carry a delay
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind != octw_pkg::KIND_RECORD) |-> (delay_ticks == 16'h0000))
        else $error("non-record result with a delay");
`endif

endmodule
